>>> hdl/urb_pkg.sv
// ----------------------------------------------------------------------------
// urb_pkg
// Types, constants and ring pointer helpers for the UART ring buffer block.
// ----------------------------------------------------------------------------
package urb_pkg;

  localparam int unsigned BufferDepth = 64;
  localparam int unsigned PtrW        = $clog2(BufferDepth);
  localparam int unsigned LvlW        = 6;
  localparam int unsigned CntW        = 6;
  localparam int unsigned CmpW        = (PtrW > LvlW) ? PtrW : LvlW;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned CfgAddrW    = 4;
  localparam int unsigned CfgDataW    = 32;

  localparam logic [ByteW-1:0] CharXon  = 8'd17;
  localparam logic [ByteW-1:0] CharXoff = 8'd19;

  localparam logic [LvlW-1:0] XoffLvlReset = 6'd16;
  localparam logic [LvlW-1:0] XonLvlReset  = 6'd16;

  typedef logic [PtrW-1:0] ptr_t;

  typedef enum logic [1:0] {
    CmdRxByte    = 2'd0,
    CmdTxReady   = 2'd1,
    CmdHostRead  = 2'd2,
    CmdHostWrite = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RegFlowEn  = 2'd0,
    RegXoffLvl = 2'd1,
    RegXonLvl  = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StHold
  } state_e;

  typedef struct packed {
    logic send_xon;
    logic send_xoff;
    logic state_on;
  } flow_t;

  typedef struct packed {
    logic            flow_control_enable;
    logic [LvlW-1:0] xoff_free_level;
    logic [LvlW-1:0] xon_fill_level;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } ctrl_t;

  typedef struct packed {
    logic [ByteW-1:0] read_data;
    logic             read_valid;
    logic             send_valid;
    logic [ByteW-1:0] send_byte;
    logic             write_accepted;
    logic             receive_dropped;
    logic [CntW-1:0]  receive_count;
    logic [CntW-1:0]  transmit_free;
    logic             transmit_request;
    logic             flow_stopped;
  } result_t;

  function automatic ptr_t ring_next(ptr_t p);
    return (p == ptr_t'(BufferDepth - 1)) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  function automatic ptr_t ring_used(ptr_t head, ptr_t tail);
    logic [PtrW:0] sum;
    sum = {1'b0, head} + (PtrW+1)'(BufferDepth) - {1'b0, tail};
    if (sum >= (PtrW+1)'(BufferDepth)) begin
      sum = sum - (PtrW+1)'(BufferDepth);
    end
    return sum[PtrW-1:0];
  endfunction

  function automatic ptr_t ring_free(ptr_t head, ptr_t tail);
    return ptr_t'(BufferDepth - 1) - ring_used(head, tail);
  endfunction

  function automatic logic [CntW-1:0] to_cnt(ptr_t p);
    logic [CmpW-1:0] w;
    w = CmpW'(p);
    return w[CntW-1:0];
  endfunction

endpackage

>>> hdl/urb_in_if.sv
// ----------------------------------------------------------------------------
// urb_in_if
// Request channel: command and data byte with valid/ready handshake.
// ----------------------------------------------------------------------------
interface urb_in_if;
  import urb_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       command;
  logic [ByteW-1:0] data_byte;

  modport source (output valid, command, data_byte, input ready);
  modport sink   (input valid, command, data_byte, output ready);
endinterface

>>> hdl/urb_out_if.sv
// ----------------------------------------------------------------------------
// urb_out_if
// Result channel: one result per request with valid/ready handshake.
// ----------------------------------------------------------------------------
interface urb_out_if;
  import urb_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] read_data;
  logic             read_valid;
  logic             send_valid;
  logic [ByteW-1:0] send_byte;
  logic             write_accepted;
  logic             receive_dropped;
  logic [CntW-1:0]  receive_count;
  logic [CntW-1:0]  transmit_free;
  logic             transmit_request;
  logic             flow_stopped;

  modport source (
    output valid, read_data, read_valid, send_valid, send_byte, write_accepted,
           receive_dropped, receive_count, transmit_free, transmit_request,
           flow_stopped,
    input  ready
  );
  modport sink (
    input  valid, read_data, read_valid, send_valid, send_byte, write_accepted,
           receive_dropped, receive_count, transmit_free, transmit_request,
           flow_stopped,
    output ready
  );
endinterface

>>> hdl/urb_ram.sv
// ----------------------------------------------------------------------------
// urb_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module urb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/urb_ctrl.sv
// ----------------------------------------------------------------------------
// urb_ctrl
// Sequencer: accept a request, execute it, hold the result until taken.
// ----------------------------------------------------------------------------
module urb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output urb_pkg::ctrl_t ctrl_o
);
  import urb_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    out_valid_o    = 1'b0;
    ctrl_o.capture = 1'b0;
    ctrl_o.exec    = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = StExec;
        end
      end
      StExec: begin
        ctrl_o.exec = 1'b1;
        state_d     = StHold;
      end
      StHold: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

>>> hdl/urb_datapath.sv
// ----------------------------------------------------------------------------
// urb_datapath
// Ring pointers, buffer memories, flow control flags and result register.
// ----------------------------------------------------------------------------
module urb_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  urb_pkg::ctrl_t          ctrl_i,
  input  urb_pkg::cfg_t           cfg_i,
  input  logic [1:0]              command_i,
  input  logic [urb_pkg::ByteW-1:0] data_byte_i,
  output urb_pkg::result_t        result_o
);
  import urb_pkg::*;

  cmd_e             cmd_q;
  logic [ByteW-1:0] data_q;

  ptr_t  rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  ptr_t  tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  flow_t flow_q, flow_d;
  logic  want_q, want_d;

  result_t res_q, res_d;

  logic             rx_we, tx_we;
  logic [ByteW-1:0] rx_rdata, tx_rdata;

  ptr_t rx_used, rx_free, tx_used, tx_free;

  assign rx_used = ring_used(rx_head_q, rx_tail_q);
  assign rx_free = ring_free(rx_head_q, rx_tail_q);
  assign tx_used = ring_used(tx_head_q, tx_tail_q);
  assign tx_free = ring_free(tx_head_q, tx_tail_q);

  assign rx_we = ctrl_i.exec && (cmd_q == CmdRxByte) && (rx_free != '0);
  assign tx_we = ctrl_i.exec && (cmd_q == CmdHostWrite) && (tx_free != '0);

  // read port always points at the tail, data is ready by the exec cycle
  urb_ram #(.Width(ByteW), .Depth(BufferDepth)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_head_q),
    .wdata_i (data_q),
    .raddr_i (rx_tail_q),
    .rdata_o (rx_rdata)
  );

  urb_ram #(.Width(ByteW), .Depth(BufferDepth)) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_head_q),
    .wdata_i (data_q),
    .raddr_i (tx_tail_q),
    .rdata_o (tx_rdata)
  );

  always_comb begin
    rx_head_d = rx_head_q;
    rx_tail_d = rx_tail_q;
    tx_head_d = tx_head_q;
    tx_tail_d = tx_tail_q;
    flow_d    = flow_q;
    want_d    = want_q;
    res_d     = '0;
    unique case (cmd_q)
      CmdRxByte: begin
        if (rx_free != '0) begin
          rx_head_d = ring_next(rx_head_q);
        end else begin
          res_d.receive_dropped = 1'b1;
        end
        if (cfg_i.flow_control_enable && flow_q.state_on &&
            (CmpW'(ring_free(rx_head_d, rx_tail_q)) <= CmpW'(cfg_i.xoff_free_level))) begin
          flow_d = '{send_xon: 1'b0, send_xoff: 1'b1, state_on: 1'b1};
          want_d = 1'b1;
        end
      end
      CmdTxReady: begin
        if (cfg_i.flow_control_enable && flow_q.send_xon) begin
          res_d.send_valid = 1'b1;
          res_d.send_byte  = CharXon;
          flow_d           = '{send_xon: 1'b0, send_xoff: 1'b0, state_on: 1'b1};
        end else if (cfg_i.flow_control_enable && flow_q.send_xoff) begin
          res_d.send_valid = 1'b1;
          res_d.send_byte  = CharXoff;
          flow_d           = '0;
        end else if (tx_used != '0) begin
          res_d.send_valid = 1'b1;
          res_d.send_byte  = tx_rdata;
          tx_tail_d        = ring_next(tx_tail_q);
        end else begin
          want_d = 1'b0;
        end
      end
      CmdHostRead: begin
        if (rx_used != '0) begin
          res_d.read_valid = 1'b1;
          res_d.read_data  = rx_rdata;
          rx_tail_d        = ring_next(rx_tail_q);
        end
        if (cfg_i.flow_control_enable && !flow_q.state_on &&
            (CmpW'(ring_used(rx_head_q, rx_tail_d)) <= CmpW'(cfg_i.xon_fill_level))) begin
          flow_d = '{send_xon: 1'b1, send_xoff: 1'b0, state_on: 1'b0};
          want_d = 1'b1;
        end
      end
      CmdHostWrite: begin
        if (tx_free != '0) begin
          tx_head_d            = ring_next(tx_head_q);
          res_d.write_accepted = 1'b1;
        end
        want_d = 1'b1;
      end
      default: begin
      end
    endcase
    res_d.receive_count    = to_cnt(ring_used(rx_head_d, rx_tail_d));
    res_d.transmit_free    = to_cnt(ring_free(tx_head_d, tx_tail_d));
    res_d.transmit_request = want_d;
    res_d.flow_stopped     = !flow_d.state_on;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q <= '0;
      rx_tail_q <= '0;
      tx_head_q <= '0;
      tx_tail_q <= '0;
      flow_q    <= '{send_xon: 1'b1, send_xoff: 1'b0, state_on: 1'b0};
      want_q    <= 1'b1;
    end else if (ctrl_i.exec) begin
      rx_head_q <= rx_head_d;
      rx_tail_q <= rx_tail_d;
      tx_head_q <= tx_head_d;
      tx_tail_q <= tx_tail_d;
      flow_q    <= flow_d;
      want_q    <= want_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q  <= cmd_e'(command_i);
      data_q <= data_byte_i;
    end
    if (ctrl_i.exec) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

endmodule

>>> hdl/uart_ring_buffers_xon_xoff_top.sv
// ----------------------------------------------------------------------------
// uart_ring_buffers_xon_xoff_top
// Receive and transmit ring buffers with XON/XOFF flow control.
// A request is captured in StIdle, executed in StExec through the registered
// buffer memory read, and its result is held in StHold until taken; no new
// request is accepted until then, and the hold lasts while out is stalled.
// Reset: pointers cleared, XON pending, flow state off, transmit request set.
// Buffer memories are not cleared; entries are read only after being written.
// ----------------------------------------------------------------------------
module uart_ring_buffers_xon_xoff_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  urb_in_if.sink                        in_i,
  urb_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [urb_pkg::CfgAddrW-1:0]  paddr,
  input  logic [urb_pkg::CfgDataW-1:0]  pwdata,
  output logic [urb_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);
  import urb_pkg::*;

  cfg_t     cfg_q;
  ctrl_t    ctrl;
  result_t  result;
  reg_idx_e reg_idx;
  logic     cfg_we;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flow_control_enable <= 1'b1;
      cfg_q.xoff_free_level     <= XoffLvlReset;
      cfg_q.xon_fill_level      <= XonLvlReset;
    end else if (cfg_we) begin
      unique case (reg_idx)
        RegFlowEn:  cfg_q.flow_control_enable <= pwdata[0];
        RegXoffLvl: cfg_q.xoff_free_level     <= pwdata[LvlW-1:0];
        RegXonLvl:  cfg_q.xon_fill_level      <= pwdata[LvlW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegFlowEn:  prdata = CfgDataW'(cfg_q.flow_control_enable);
      RegXoffLvl: prdata = CfgDataW'(cfg_q.xoff_free_level);
      RegXonLvl:  prdata = CfgDataW'(cfg_q.xon_fill_level);
      default:    prdata = '0;
    endcase
  end

  urb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .ctrl_o      (ctrl)
  );

  urb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cfg_i       (cfg_q),
    .command_i   (in_i.command),
    .data_byte_i (in_i.data_byte),
    .result_o    (result)
  );

  assign out_o.read_data        = result.read_data;
  assign out_o.read_valid       = result.read_valid;
  assign out_o.send_valid       = result.send_valid;
  assign out_o.send_byte        = result.send_byte;
  assign out_o.write_accepted   = result.write_accepted;
  assign out_o.receive_dropped  = result.receive_dropped;
  assign out_o.receive_count    = result.receive_count;
  assign out_o.transmit_free    = result.transmit_free;
  assign out_o.transmit_request = result.transmit_request;
  assign out_o.flow_stopped     = result.flow_stopped;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the UART ring buffer block with XON/XOFF flow control. A short table
// of requests and register writes covers reset flow state, data extremes, every
// command, repeated XOFF and disabled flow control; random bursts that flood or
// drain either ring follow under several register settings. Every result is
// compared field by field, with random stalls on both channels, against the
// table's result if given, else a cycle-free model of both rings and flags.
// ----------------------------------------------------------------------------
module tb;
  import urb_pkg::*;

  typedef enum int {
    BurstMixed,
    BurstRxFlood,
    BurstTxFlood,
    BurstDrain
  } burst_e;

  typedef struct packed {
    logic             is_cfg;
    reg_idx_e         cfg_idx;
    cmd_e             cmd;
    logic [ByteW-1:0] value;
    logic             known;
    result_t          res;
  } stim_row_t;

  localparam int NumRows = 30;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  urb_in_if  in_if ();
  urb_out_if out_if ();

  uart_ring_buffers_xon_xoff_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // buffer model state
  logic [ByteW-1:0] rx_bytes [BufferDepth];
  logic [ByteW-1:0] tx_bytes [BufferDepth];
  ptr_t  rx_head, rx_tail, tx_head, tx_tail;
  flow_t flow;
  logic  tx_wanted;
  cfg_t  cfg;

  result_t event_results_q [$];
  int fail_count = 0;
  int req_count = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;

  function automatic ptr_t ring_level(ptr_t head, ptr_t tail);
    return ptr_t'(head - tail);
  endfunction

  function automatic result_t apply_event(cmd_e c, logic [ByteW-1:0] d);
    result_t r;
    r = '0;
    case (c)
      CmdRxByte: begin
        if (ring_level(rx_head, rx_tail) != ptr_t'(BufferDepth - 1)) begin
          rx_bytes[rx_head] = d;
          rx_head = rx_head + 1'b1;
        end else begin
          r.receive_dropped = 1'b1;
        end
        if (cfg.flow_control_enable && flow.state_on &&
            ptr_t'(BufferDepth - 1) - ring_level(rx_head, rx_tail) <= cfg.xoff_free_level) begin
          flow = '{send_xon: 1'b0, send_xoff: 1'b1, state_on: 1'b1};
          tx_wanted = 1'b1;
        end
      end
      CmdTxReady: begin
        if (cfg.flow_control_enable && flow.send_xon) begin
          r.send_valid = 1'b1;
          r.send_byte = CharXon;
          flow = '{send_xon: 1'b0, send_xoff: 1'b0, state_on: 1'b1};
        end else if (cfg.flow_control_enable && flow.send_xoff) begin
          r.send_valid = 1'b1;
          r.send_byte = CharXoff;
          flow = '0;
        end else if (ring_level(tx_head, tx_tail) != '0) begin
          r.send_valid = 1'b1;
          r.send_byte = tx_bytes[tx_tail];
          tx_tail = tx_tail + 1'b1;
        end else begin
          tx_wanted = 1'b0;
        end
      end
      CmdHostRead: begin
        if (ring_level(rx_head, rx_tail) != '0) begin
          r.read_valid = 1'b1;
          r.read_data = rx_bytes[rx_tail];
          rx_tail = rx_tail + 1'b1;
        end
        if (cfg.flow_control_enable && !flow.state_on &&
            ring_level(rx_head, rx_tail) <= cfg.xon_fill_level) begin
          flow = '{send_xon: 1'b1, send_xoff: 1'b0, state_on: 1'b0};
          tx_wanted = 1'b1;
        end
      end
      default: begin
        if (ring_level(tx_head, tx_tail) != ptr_t'(BufferDepth - 1)) begin
          tx_bytes[tx_head] = d;
          tx_head = tx_head + 1'b1;
          r.write_accepted = 1'b1;
        end
        tx_wanted = 1'b1;
      end
    endcase
    r.receive_count = CntW'(ring_level(rx_head, rx_tail));
    r.transmit_free = CntW'(ptr_t'(BufferDepth - 1) - ring_level(tx_head, tx_tail));
    r.transmit_request = tx_wanted;
    r.flow_stopped = !flow.state_on;
    return r;
  endfunction

  function automatic result_t known_result(int rd, int rv, int sv, int sb, int wa, int dr,
                                           int rc, int tf, int tr, int fs);
    result_t r;
    r.read_data = ByteW'(rd);
    r.read_valid = rv[0];
    r.send_valid = sv[0];
    r.send_byte = ByteW'(sb);
    r.write_accepted = wa[0];
    r.receive_dropped = dr[0];
    r.receive_count = CntW'(rc);
    r.transmit_free = CntW'(tf);
    r.transmit_request = tr[0];
    r.flow_stopped = fs[0];
    return r;
  endfunction

  function automatic stim_row_t ev_row(cmd_e c, logic [ByteW-1:0] v);
    stim_row_t s;
    s = '0;
    s.cmd = c;
    s.value = v;
    return s;
  endfunction

  function automatic stim_row_t ev_row_known(cmd_e c, logic [ByteW-1:0] v, result_t res);
    stim_row_t s;
    s = ev_row(c, v);
    s.known = 1'b1;
    s.res = res;
    return s;
  endfunction

  function automatic stim_row_t cfg_row(reg_idx_e idx, logic [ByteW-1:0] v);
    stim_row_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.cfg_idx = idx;
    s.value = v;
    return s;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result(result_t want, result_t got);
    check_field("read_data", want.read_data, got.read_data);
    check_field("read_valid", want.read_valid, got.read_valid);
    check_field("send_valid", want.send_valid, got.send_valid);
    check_field("send_byte", want.send_byte, got.send_byte);
    check_field("write_accepted", want.write_accepted, got.write_accepted);
    check_field("receive_dropped", want.receive_dropped, got.receive_dropped);
    check_field("receive_count", want.receive_count, got.receive_count);
    check_field("transmit_free", want.transmit_free, got.transmit_free);
    check_field("transmit_request", want.transmit_request, got.transmit_request);
    check_field("flow_stopped", want.flow_stopped, got.flow_stopped);
  endtask

  task automatic offer_event(cmd_e c, logic [ByteW-1:0] d, logic known, result_t known_res);
    result_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.command <= c;
    in_if.data_byte <= d;
    do @(posedge clk_i); while (!in_if.ready);
    r = apply_event(c, d);
    event_results_q.push_back(known ? known_res : r);
    req_count++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (event_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_idx_e idx, logic [CfgDataW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegFlowEn:  cfg.flow_control_enable = val[0];
      RegXoffLvl: cfg.xoff_free_level = val[LvlW-1:0];
      default:    cfg.xon_fill_level = val[LvlW-1:0];
    endcase
    // read back
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== val) begin
      $error("register %s: expected 'h%0h, got 'h%0h", idx.name(), val, prdata);
      fail_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // result side: random stalls, one long hold-off, checking
  initial begin
    result_t got;
    int      hold_left;
    bit      long_hold_done;
    hold_left = 0;
    long_hold_done = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got = '{read_data: out_if.read_data, read_valid: out_if.read_valid,
                send_valid: out_if.send_valid, send_byte: out_if.send_byte,
                write_accepted: out_if.write_accepted,
                receive_dropped: out_if.receive_dropped,
                receive_count: out_if.receive_count, transmit_free: out_if.transmit_free,
                transmit_request: out_if.transmit_request,
                flow_stopped: out_if.flow_stopped};
        if (event_results_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          check_result(event_results_q.pop_front(), got);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (!long_hold_done && req_count >= 400) begin
        long_hold_done = 1'b1;
        hold_left = 300;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin
    stim_row_t rows [NumRows];
    cfg_t      plan [6];
    burst_e    mode;
    cmd_e      c;
    int        total, n, seg, p;

    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.command <= CmdRxByte;
    in_if.data_byte <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;

    rx_head = '0;
    rx_tail = '0;
    tx_head = '0;
    tx_tail = '0;
    flow = '{send_xon: 1'b1, send_xoff: 1'b0, state_on: 1'b0};
    tx_wanted = 1'b1;
    cfg = '{flow_control_enable: 1'b1, xoff_free_level: XoffLvlReset,
            xon_fill_level: XonLvlReset};

    rows = '{
      ev_row_known(CmdHostRead, 8'hFF, known_result(0, 0, 0, 0, 0, 0, 0, 63, 1, 1)),
      ev_row_known(CmdTxReady, 8'h00, known_result(0, 0, 1, CharXon, 0, 0, 0, 63, 1, 0)),
      ev_row_known(CmdTxReady, 8'hFF, known_result(0, 0, 0, 0, 0, 0, 0, 63, 0, 0)),
      ev_row_known(CmdHostWrite, 8'hFF, known_result(0, 0, 0, 0, 1, 0, 0, 62, 1, 0)),
      ev_row_known(CmdHostWrite, 8'h00, known_result(0, 0, 0, 0, 1, 0, 0, 61, 1, 0)),
      ev_row_known(CmdTxReady, 8'h00, known_result(0, 0, 1, 'hFF, 0, 0, 0, 62, 1, 0)),
      ev_row_known(CmdTxReady, 8'hFF, known_result(0, 0, 1, 0, 0, 0, 0, 63, 1, 0)),
      ev_row_known(CmdRxByte, 8'hFF, known_result(0, 0, 0, 0, 0, 0, 1, 63, 1, 0)),
      ev_row_known(CmdRxByte, 8'h00, known_result(0, 0, 0, 0, 0, 0, 2, 63, 1, 0)),
      ev_row(CmdRxByte, 8'hA5),
      ev_row_known(CmdHostRead, 8'h00, known_result('hFF, 1, 0, 0, 0, 0, 2, 63, 1, 0)),
      ev_row_known(CmdHostRead, 8'hFF, known_result(0, 1, 0, 0, 0, 0, 1, 63, 1, 0)),
      ev_row(CmdHostRead, 8'h5A),
      ev_row(CmdHostRead, 8'h00),
      ev_row(CmdTxReady, 8'h00),
      // repeated xoff
      cfg_row(RegXoffLvl, 8'd63),
      ev_row(CmdRxByte, 8'h5A),
      ev_row(CmdRxByte, 8'h3C),
      ev_row_known(CmdTxReady, 8'h00, known_result(0, 0, 1, CharXoff, 0, 0, 2, 63, 1, 1)),
      ev_row(CmdRxByte, 8'hC3),
      // flow control off
      cfg_row(RegFlowEn, 8'd0),
      ev_row(CmdHostRead, 8'h00),
      ev_row(CmdTxReady, 8'hFF),
      ev_row(CmdHostWrite, 8'h77),
      ev_row(CmdTxReady, 8'h00),
      cfg_row(RegFlowEn, 8'd1),
      cfg_row(RegXonLvl, 8'd63),
      ev_row(CmdHostRead, 8'h00),
      ev_row(CmdTxReady, 8'h00),
      ev_row(CmdHostRead, 8'h00)
    };

    plan[0] = '{flow_control_enable: 1'b1, xoff_free_level: 6'd16, xon_fill_level: 6'd16};
    plan[1] = '{flow_control_enable: 1'b0, xoff_free_level: 6'd0, xon_fill_level: 6'd0};
    plan[2] = '{flow_control_enable: 1'b1, xoff_free_level: 6'd63, xon_fill_level: 6'd63};
    plan[3] = '{flow_control_enable: 1'b1, xoff_free_level: 6'd0, xon_fill_level: 6'd63};
    plan[4] = '{flow_control_enable: 1'b1, xoff_free_level: 6'd63, xon_fill_level: 6'd0};
    plan[5] = '{flow_control_enable: 1'b1, xoff_free_level: LvlW'($urandom_range(63)),
                xon_fill_level: LvlW'($urandom_range(63))};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 21;
    sink_idle_pct = 62;
    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        wait_drained();
        reg_write(rows[i].cfg_idx, CfgDataW'(rows[i].value));
      end else begin
        offer_event(rows[i].cmd, rows[i].value, rows[i].known, rows[i].res);
      end
    end

    total = 0;
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      reg_write(RegFlowEn, CfgDataW'(plan[ph].flow_control_enable));
      reg_write(RegXoffLvl, CfgDataW'(plan[ph].xoff_free_level));
      reg_write(RegXonLvl, CfgDataW'(plan[ph].xon_fill_level));
      n = 0;
      while (n < 125) begin
        mode = burst_e'($urandom_range(3));
        seg = $urandom_range(120, 30);
        for (int k = 0; k < seg && n < 125; k++) begin
          p = $urandom_range(99);
          case (mode)
            BurstRxFlood: c = (p < 88) ? CmdRxByte : (p < 92) ? CmdHostRead :
                              (p < 96) ? CmdTxReady : CmdHostWrite;
            BurstTxFlood: c = (p < 85) ? CmdHostWrite : (p < 93) ? CmdTxReady :
                              (p < 97) ? CmdRxByte : CmdHostRead;
            BurstDrain:   c = (p < 45) ? CmdHostRead : (p < 90) ? CmdTxReady :
                              (p < 95) ? CmdRxByte : CmdHostWrite;
            default:      c = cmd_e'($urandom_range(3));
          endcase
          if (total < 250) begin
            src_idle_pct = 21;
            sink_idle_pct = 62;
          end else if (total < 500) begin
            src_idle_pct = 62;
            sink_idle_pct = 21;
          end else begin
            src_idle_pct = 0;
            sink_idle_pct = 0;
          end
          offer_event(c, ByteW'($urandom_range(255)), 1'b0, '0);
          n++;
          total++;
        end
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
